[src/mpjs_pkg.sv]
// ----------------------------------------------------------------------------
// mpjs_pkg
// shared types and constants of the multi-policy job scheduler
// ----------------------------------------------------------------------------
package mpjs_pkg;

  localparam int SLOT_W     = 6;
  localparam int REM_W      = 16;
  localparam int QUANT_W    = 8;
  localparam int POL_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [QUANT_W-1:0] QUANT_RST = 8'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 2'd1;

  // item kinds
  localparam logic ACT_ADMIT = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  typedef enum logic [POL_W-1:0] {
    POL_FCFS = 2'd0,
    POL_SJF  = 2'd1,
    POL_SRTF = 2'd2,
    POL_RR   = 2'd3
  } policy_e;

  typedef enum logic {
    SCAN_FIRST    = 1'b0,
    SCAN_SHORTEST = 1'b1
  } scan_mode_e;

  typedef enum logic [1:0] {
    CTX_ADMIT = 2'd0,
    CTX_PRE   = 2'd1,
    CTX_POST  = 2'd2
  } scan_ctx_e;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'd0,
    ST_IDLE   = 3'd1,
    ST_WRAP   = 3'd2,
    ST_ADM_RD = 3'd3,
    ST_ADM_WR = 3'd4,
    ST_SCAN   = 3'd5,
    ST_RUN    = 3'd6,
    ST_DONE   = 3'd7
  } state_e;

  typedef struct packed {
    logic       start;
    scan_mode_e mode;
  } scan_req_t;

  typedef struct packed {
    logic done;
    logic found;
  } scan_res_t;

endpackage

[src/mpjs_ram.sv]
// ----------------------------------------------------------------------------
// mpjs_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module mpjs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/mpjs_scan.sv]
// ----------------------------------------------------------------------------
// mpjs_scan
// sequential slot scanner: first live slot or shortest live slot
// ----------------------------------------------------------------------------
module mpjs_scan import mpjs_pkg::*; #(
  parameter int SLOTS = 64,
  localparam int IW   = $clog2(SLOTS),
  localparam int CW   = $clog2(SLOTS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  scan_req_t        req_i,
  input  logic [IW-1:0]    start_idx_i,
  output logic [IW-1:0]    rd_addr_o,
  input  logic [REM_W-1:0] rd_data_i,
  output scan_res_t        res_o,
  output logic [IW-1:0]    best_idx_o,
  output logic [REM_W-1:0] best_val_o
);

  logic             busy_q, busy_d;
  logic             pend_q, pend_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [IW-1:0]    addr_q, addr_d;
  logic [IW-1:0]    paddr_q;
  scan_mode_e       mode_q;
  logic             found_q, found_d;
  logic [IW-1:0]    best_idx_q, best_idx_d;
  logic [REM_W-1:0] best_val_q, best_val_d;
  logic             issue;
  logic             take;
  logic             done;

  assign issue = busy_q && (cnt_q != CW'(SLOTS));
  assign done  = busy_q && (cnt_q == CW'(SLOTS)) && !pend_q;

  always_comb begin
    take = 1'b0;
    if (pend_q && (rd_data_i != '0)) begin
      if (mode_q == SCAN_FIRST) begin
        take = !found_q;
      end else begin
        take = !found_q || (rd_data_i < best_val_q);
      end
    end
  end

  always_comb begin
    busy_d     = busy_q;
    pend_d     = issue;
    cnt_d      = cnt_q;
    addr_d     = addr_q;
    found_d    = found_q || take;
    best_idx_d = take ? paddr_q : best_idx_q;
    best_val_d = take ? rd_data_i : best_val_q;
    if (issue) begin
      cnt_d  = cnt_q + 1'b1;
      addr_d = (addr_q == IW'(SLOTS - 1)) ? '0 : addr_q + 1'b1;
    end
    if (done) begin
      busy_d = 1'b0;
    end
    if (req_i.start) begin
      busy_d  = 1'b1;
      pend_d  = 1'b0;
      cnt_d   = '0;
      addr_d  = start_idx_i;
      found_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pend_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    paddr_q    <= addr_q;
    found_q    <= found_d;
    best_idx_q <= best_idx_d;
    best_val_q <= best_val_d;
    if (req_i.start) begin
      mode_q <= req_i.mode;
    end
  end

  assign rd_addr_o   = addr_q;
  assign res_o.done  = done;
  assign res_o.found = found_q;
  assign best_idx_o  = best_idx_q;
  assign best_val_o  = best_val_q;

endmodule

[src/multi_policy_job_scheduler_top.sv]
// ----------------------------------------------------------------------------
// multi_policy_job_scheduler_top
// job scheduler with fcfs, sjf, srtf and round robin selection over a slot
// table of remaining bursts
// ----------------------------------------------------------------------------
// sequence: an admit passes the wrap, read and write states, under srtf
// followed by one slot scan; a tick runs the job plus up to two slot scans
// throughput: one item at a time; the scan reads one table entry per cycle
// through the single ram read port and a single comparator
// reset: after rst_ni a clearing pass writes zero to every slot with
// in_stall_o high; configuration writes are taken throughout
// ----------------------------------------------------------------------------
module multi_policy_job_scheduler_top import mpjs_pkg::*; #(
  parameter int SLOTS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  in_action_i,
  input  logic [SLOT_W-1:0]     in_slot_i,
  input  logic [REM_W-1:0]      in_burst_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SLOT_W-1:0]     out_running_slot_o,
  output logic [REM_W-1:0]      out_running_remaining_o,
  output logic                  out_idle_o,
  output logic                  out_finished_o,
  output logic                  out_switched_o,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int IW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);
  // slot register wide enough to hold SLOTS itself and the 6-bit input
  localparam int SW = (IW >= SLOT_W) ? IW + 1 : SLOT_W + 1;

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  state_e            state_q, state_d;
  scan_ctx_e         ctx_q, ctx_d;
  logic [IW-1:0]     clr_q, clr_d;

  // latched transaction
  logic              act_q;
  logic [SW-1:0]     slot_q, slot_d;
  logic [REM_W-1:0]  burst_q;
  logic [IW-1:0]     before_q;
  logic              fin_q, fin_d;

  // scheduler state outside the table; run_rem_q mirrors table[run_idx_q]
  logic [IW-1:0]     run_idx_q, run_idx_d;
  logic [REM_W-1:0]  run_rem_q, run_rem_d;
  logic [LW-1:0]     live_q, live_d;
  logic [QUANT_W-1:0] ql_q, ql_d;

  // configuration
  policy_e           policy_q;
  logic [QUANT_W-1:0] quantum_q;

  // result register
  logic              out_valid_q;
  logic              out_ld;
  logic [SLOT_W-1:0] out_slot_q;
  logic [REM_W-1:0]  out_rem_q;
  logic              out_idle_q;
  logic              out_fin_q;
  logic              out_sw_q;

  // ram ports
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [REM_W-1:0]  ram_wdata;
  logic [IW-1:0]     ram_raddr;
  logic [REM_W-1:0]  ram_rdata;

  // scanner
  scan_req_t         scan_req;
  scan_res_t         scan_res;
  logic [IW-1:0]     scan_start;
  logic [IW-1:0]     scan_addr;
  logic [IW-1:0]     best_idx;
  logic [REM_W-1:0]  best_val;

  // helpers
  logic              accept;
  logic [QUANT_W-1:0] q_reload;
  logic [IW-1:0]     slot_wr;
  logic [IW-1:0]     rr_next;
  logic [REM_W-1:0]  rem_dec;
  logic [QUANT_W-1:0] ql_dec;
  logic [SW-1:0]     idx_ext;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign q_reload = (quantum_q == '0) ? QUANT_W'(1) : quantum_q;
  assign slot_wr  = slot_q[IW-1:0];
  assign rr_next  = (run_idx_q == IW'(SLOTS - 1)) ? '0 : run_idx_q + 1'b1;
  assign rem_dec  = run_rem_q - 1'b1;
  assign ql_dec   = (ql_q != '0) ? ql_q - 1'b1 : ql_q;
  assign idx_ext  = SW'(run_idx_q);

  // --------------------------------------------------------------------------
  // slot table and scanner
  // --------------------------------------------------------------------------
  mpjs_ram #(
    .WIDTH (REM_W),
    .DEPTH (SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mpjs_scan #(
    .SLOTS (SLOTS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (scan_req),
    .start_idx_i (scan_start),
    .rd_addr_o   (scan_addr),
    .rd_data_i   (ram_rdata),
    .res_o       (scan_res),
    .best_idx_o  (best_idx),
    .best_val_o  (best_val)
  );

  // the only direct read is the old value of an admitted slot
  assign ram_raddr = (state_q == ST_ADM_RD) ? slot_wr : scan_addr;

  // --------------------------------------------------------------------------
  // sequencer: next state, table writes and scan requests
  // --------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    ctx_d      = ctx_q;
    clr_d      = clr_q;
    slot_d     = slot_q;
    fin_d      = fin_q;
    run_idx_d  = run_idx_q;
    run_rem_d  = run_rem_q;
    live_d     = live_q;
    ql_d       = ql_q;
    ram_we     = 1'b0;
    ram_waddr  = run_idx_q;
    ram_wdata  = '0;
    scan_req   = '{start: 1'b0, mode: SCAN_SHORTEST};
    scan_start = '0;
    out_ld     = 1'b0;

    case (state_q)
      // zero every slot once after reset
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == IW'(SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          slot_d = SW'(in_slot_i);
          fin_d  = 1'b0;
          if (in_action_i == ACT_ADMIT) begin
            state_d = ST_WRAP;
          end else if (run_rem_q == '0) begin
            // running slot is empty: reselect before running
            state_d = ST_SCAN;
            ctx_d   = CTX_PRE;
            scan_req.start = 1'b1;
            case (policy_q)
              POL_FCFS: scan_req.mode = SCAN_FIRST;
              POL_RR: begin
                scan_req.mode = SCAN_FIRST;
                scan_start    = rr_next;
                ql_d          = q_reload;
              end
              default: scan_req.mode = SCAN_SHORTEST;
            endcase
          end else begin
            state_d = ST_RUN;
          end
        end
      end

      // slot number modulo SLOTS by repeated subtraction
      ST_WRAP: begin
        if (slot_q >= SW'(SLOTS)) begin
          slot_d = slot_q - SW'(SLOTS);
        end else begin
          state_d = ST_ADM_RD;
        end
      end

      ST_ADM_RD: begin
        state_d = ST_ADM_WR;
      end

      // old value on the read port: write the new burst, track live slots
      ST_ADM_WR: begin
        ram_we    = 1'b1;
        ram_waddr = slot_wr;
        ram_wdata = burst_q;
        if ((ram_rdata == '0) && (burst_q != '0)) begin
          live_d = live_q + 1'b1;
        end else if ((ram_rdata != '0) && (burst_q == '0)) begin
          live_d = live_q - 1'b1;
        end
        if (slot_wr == run_idx_q) begin
          run_rem_d = burst_q;
        end
        if (policy_q == POL_SRTF) begin
          state_d        = ST_SCAN;
          ctx_d          = CTX_ADMIT;
          scan_req.start = 1'b1;
          scan_req.mode  = SCAN_SHORTEST;
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_SCAN: begin
        if (scan_res.done) begin
          case (ctx_q)
            CTX_ADMIT: begin
              // preempt only for a strictly shorter job or an empty slot
              if (scan_res.found && ((run_rem_q == '0) || (best_val < run_rem_q))) begin
                run_idx_d = best_idx;
                run_rem_d = best_val;
              end
              state_d = ST_DONE;
            end
            CTX_PRE: begin
              if (scan_res.found) begin
                run_idx_d = best_idx;
                run_rem_d = best_val;
                state_d   = ST_RUN;
              end else begin
                state_d = ST_DONE;
              end
            end
            default: begin
              if (scan_res.found) begin
                run_idx_d = best_idx;
                run_rem_d = best_val;
              end
              state_d = ST_DONE;
            end
          endcase
        end
      end

      // run the selected job for one unit
      ST_RUN: begin
        ram_we    = 1'b1;
        ram_waddr = run_idx_q;
        ram_wdata = rem_dec;
        run_rem_d = rem_dec;
        state_d   = ST_DONE;
        if (rem_dec == '0) begin
          fin_d  = 1'b1;
          live_d = live_q - 1'b1;
        end
        if (policy_q == POL_RR) begin
          ql_d = ql_dec;
          if ((rem_dec == '0) || (ql_dec == '0)) begin
            state_d        = ST_SCAN;
            ctx_d          = CTX_POST;
            scan_req.start = 1'b1;
            scan_req.mode  = SCAN_FIRST;
            scan_start     = rr_next;
            ql_d           = q_reload;
          end
        end else if (rem_dec == '0) begin
          state_d        = ST_SCAN;
          ctx_d          = CTX_POST;
          scan_req.start = 1'b1;
          scan_req.mode  = (policy_q == POL_FCFS) ? SCAN_FIRST : SCAN_SHORTEST;
        end
      end

      // hand the result over once the result register is free
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_ld  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ctx_q       <= CTX_ADMIT;
      clr_q       <= '0;
      run_idx_q   <= '0;
      run_rem_q   <= '0;
      live_q      <= '0;
      ql_q        <= QUANT_RST;
      policy_q    <= POL_FCFS;
      quantum_q   <= QUANT_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ctx_q     <= ctx_d;
      clr_q     <= clr_d;
      run_idx_q <= run_idx_d;
      run_rem_q <= run_rem_d;
      live_q    <= live_d;
      ql_q      <= ql_d;
      // configuration transaction; unknown indexes are dropped
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_POLICY) begin
          policy_q <= policy_e'(cfg_data_i[POL_W-1:0]);
        end else if (cfg_index_i == CFG_QUANTUM) begin
          quantum_q <= cfg_data_i[QUANT_W-1:0];
        end
      end
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // transaction payload and result payload
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    fin_q  <= fin_d;
    if (accept) begin
      act_q    <= in_action_i;
      burst_q  <= in_burst_i;
      before_q <= run_idx_q;
    end
    if (out_ld) begin
      out_slot_q <= idx_ext[SLOT_W-1:0];
      out_rem_q  <= run_rem_q;
      out_idle_q <= (live_q == '0);
      out_fin_q  <= fin_q;
      out_sw_q   <= (run_idx_q != before_q);
    end
  end

  assign out_valid_o             = out_valid_q;
  assign out_running_slot_o      = out_slot_q;
  assign out_running_remaining_o = out_rem_q;
  assign out_idle_o              = out_idle_q;
  assign out_finished_o          = out_fin_q;
  assign out_switched_o          = out_sw_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // live slot count stays within the table
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= LW'(SLOTS))
    else $error("live slot count out of range");

  // a nonzero running job implies at least one live slot
  a_run_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_rem_q != '0) |-> (live_q != '0))
    else $error("running job live but live count is zero");

  // scanner only completes while the sequencer waits on it
  a_scan_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_res.done |-> (state_q == ST_SCAN))
    else $error("scan completed outside scan state");

  // an idle result never reports remaining work
  a_idle_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_idle_o) |-> (out_running_remaining_o == '0))
    else $error("idle result with remaining work");

  // a finished job only comes from a tick transaction
  a_fin_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && fin_q) |-> (act_q == ACT_TICK))
    else $error("finished flagged on admit");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the multi-policy job scheduler: a short directed
// table walk, then random admit and tick traffic under every policy and a
// range of quantum settings, each result checked against a scheduling model
// kept in the bench
// ----------------------------------------------------------------------------
module tb_top;
  import mpjs_pkg::*;

  localparam int NSLOTS      = 64;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 173;
  localparam int HOLD_AT     = 600;    // results seen before the long hold-off
  localparam int HOLD_CYCLES = 300;
  localparam int END_SETTLE  = 150;    // a bit over the worst tick latency
  localparam int MAX_PRINTS  = 40;

  // index with no register behind it, writes must have no effect
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [REM_W-1:0]  remaining;
    logic              idle;
    logic              finished;
    logic              switched;
  } outcome_t;

  typedef struct packed {
    policy_e            pol;
    logic [QUANT_W-1:0] quant;
    logic               act;
    logic [SLOT_W-1:0]  slot;
    logic [REM_W-1:0]   burst;
    logic               typed;   // want holds a hand-written result
    outcome_t           want;
  } stim_row_t;

  localparam outcome_t NO_CHECK = '0;

  // directed walk: reset state, field extremes, every policy, ties,
  // preemption and its absence on equal bursts, round robin quantum edges
  localparam stim_row_t DIRECTED [24] = '{
    // tick with nothing live after reset
    '{POL_FCFS, 8'd4,   ACT_TICK,  6'd0,  16'd0,    1'b1, '{6'd0, 16'd0, 1'b1, 1'b0, 1'b0}},
    // admit under fcfs keeps the empty running slot
    '{POL_FCFS, 8'd4,   ACT_ADMIT, 6'd63, 16'hFFFF, 1'b1, '{6'd0, 16'd0, 1'b0, 1'b0, 1'b0}},
    '{POL_FCFS, 8'd4,   ACT_ADMIT, 6'd0,  16'd0,    1'b1, '{6'd0, 16'd0, 1'b0, 1'b0, 1'b0}},
    '{POL_FCFS, 8'd4,   ACT_ADMIT, 6'd5,  16'd1,    1'b0, NO_CHECK},
    // empty running slot: reselect, run, finish, reselect again
    '{POL_FCFS, 8'd4,   ACT_TICK,  6'd17, 16'h5A5A, 1'b0, NO_CHECK},
    // burst zero clears the running slot
    '{POL_FCFS, 8'd4,   ACT_ADMIT, 6'd63, 16'd0,    1'b1, '{6'd63, 16'd0, 1'b1, 1'b0, 1'b0}},
    '{POL_FCFS, 8'd4,   ACT_TICK,  6'd42, 16'hFFFF, 1'b1, '{6'd63, 16'd0, 1'b1, 1'b0, 1'b0}},
    // sjf with a tie on the shortest burst
    '{POL_SJF,  8'd4,   ACT_ADMIT, 6'd10, 16'd3,    1'b0, NO_CHECK},
    '{POL_SJF,  8'd4,   ACT_ADMIT, 6'd20, 16'd3,    1'b0, NO_CHECK},
    '{POL_SJF,  8'd4,   ACT_ADMIT, 6'd30, 16'd2,    1'b0, NO_CHECK},
    '{POL_SJF,  8'd4,   ACT_TICK,  6'd0,  16'd0,    1'b0, NO_CHECK},
    '{POL_SJF,  8'd4,   ACT_TICK,  6'd0,  16'd0,    1'b0, NO_CHECK},
    // srtf: strictly shorter preempts, equal does not, emptied slot switches
    '{POL_SRTF, 8'd4,   ACT_ADMIT, 6'd40, 16'd1,    1'b0, NO_CHECK},
    '{POL_SRTF, 8'd4,   ACT_ADMIT, 6'd41, 16'd1,    1'b0, NO_CHECK},
    '{POL_SRTF, 8'd4,   ACT_ADMIT, 6'd40, 16'd0,    1'b0, NO_CHECK},
    '{POL_SRTF, 8'd4,   ACT_TICK,  6'd0,  16'd0,    1'b0, NO_CHECK},
    // round robin, shortest quantum and circular wrap past slot 63
    '{POL_RR,   8'd1,   ACT_ADMIT, 6'd63, 16'd2,    1'b0, NO_CHECK},
    '{POL_RR,   8'd1,   ACT_TICK,  6'd0,  16'd0,    1'b0, NO_CHECK},
    '{POL_RR,   8'd1,   ACT_TICK,  6'd0,  16'd0,    1'b0, NO_CHECK},
    '{POL_RR,   8'd1,   ACT_TICK,  6'd0,  16'd0,    1'b0, NO_CHECK},
    // quantum register zero acts as one
    '{POL_RR,   8'd0,   ACT_TICK,  6'd0,  16'd0,    1'b0, NO_CHECK},
    '{POL_RR,   8'd0,   ACT_TICK,  6'd0,  16'd0,    1'b0, NO_CHECK},
    '{POL_RR,   8'd255, ACT_ADMIT, 6'd7,  16'h8000, 1'b0, NO_CHECK},
    '{POL_RR,   8'd255, ACT_TICK,  6'd0,  16'd0,    1'b0, NO_CHECK}
  };

  // random phases: every policy, quantum extremes included
  localparam policy_e PHASE_POL [PHASES] = '{POL_FCFS, POL_SJF, POL_SRTF, POL_RR, POL_RR,
                                             POL_RR, POL_SRTF, POL_RR, POL_SJF, POL_FCFS};
  localparam logic [QUANT_W-1:0] PHASE_QUANT [PHASES] = '{8'd255, 8'd1, 8'd0, 8'd1, 8'd255,
                                                          8'd2, 8'd7, 8'd0, 8'd3, 8'd128};

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #2 clk = ~clk;

  // block inputs, all known from time zero
  logic                  in_valid  = 1'b0;
  logic                  in_action = ACT_ADMIT;
  logic [SLOT_W-1:0]     in_slot   = '0;
  logic [REM_W-1:0]      in_burst  = '0;
  logic                  out_stall = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_POLICY;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // block outputs
  logic                  in_stall;
  logic                  out_valid;
  logic [SLOT_W-1:0]     out_slot;
  logic [REM_W-1:0]      out_remaining;
  logic                  out_idle;
  logic                  out_finished;
  logic                  out_switched;
  logic                  cfg_ready;

  multi_policy_job_scheduler_top #(
    .SLOTS(NSLOTS)
  ) DUT (
    .clk_i                  (clk),
    .rst_ni                 (rst_n),
    .in_valid_i             (in_valid),
    .in_stall_o             (in_stall),
    .in_action_i            (in_action),
    .in_slot_i              (in_slot),
    .in_burst_i             (in_burst),
    .out_valid_o            (out_valid),
    .out_stall_i            (out_stall),
    .out_running_slot_o     (out_slot),
    .out_running_remaining_o(out_remaining),
    .out_idle_o             (out_idle),
    .out_finished_o         (out_finished),
    .out_switched_o         (out_switched),
    .cfg_valid_i            (cfg_valid),
    .cfg_ready_o            (cfg_ready),
    .cfg_index_i            (cfg_index),
    .cfg_data_i             (cfg_data)
  );

  // --------------------------------------------------------------------------
  // scheduling model: slot table, running slot, quantum countdown, registers
  // --------------------------------------------------------------------------
  logic [REM_W-1:0]   burst_left [NSLOTS];
  logic [SLOT_W-1:0]  run_slot;
  logic [QUANT_W-1:0] turns_left;
  logic [QUANT_W-1:0] quantum_reg;
  policy_e            sel_policy;

  outcome_t outcome_q [$];   // predicted results, oldest first
  int       mismatches   = 0;
  int       results_seen = 0;

  function automatic logic any_live();
    int i;
    for (i = 0; i < NSLOTS; i++)
      if (burst_left[i] != '0) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [SLOT_W-1:0] pick_lowest(input logic [SLOT_W-1:0] keep);
    int i;
    for (i = 0; i < NSLOTS; i++)
      if (burst_left[i] != '0) return SLOT_W'(i);
    return keep;
  endfunction

  // shortest remaining burst, ties to the lowest slot
  function automatic logic [SLOT_W-1:0] pick_shortest(input logic [SLOT_W-1:0] keep);
    logic [SLOT_W-1:0] best;
    logic              found;
    int                i;
    best  = keep;
    found = 1'b0;
    for (i = 0; i < NSLOTS; i++) begin
      if (burst_left[i] != '0 && (!found || burst_left[i] < burst_left[best])) begin
        best  = SLOT_W'(i);
        found = 1'b1;
      end
    end
    return best;
  endfunction

  // next live slot after keep, wrapping, keep itself checked last
  function automatic logic [SLOT_W-1:0] pick_next_rr(input logic [SLOT_W-1:0] keep);
    int k;
    int idx;
    for (k = 1; k <= NSLOTS; k++) begin
      idx = (int'(keep) + k) % NSLOTS;
      if (burst_left[idx] != '0) return SLOT_W'(idx);
    end
    return keep;
  endfunction

  function automatic logic [SLOT_W-1:0] pick_by_policy(input logic [SLOT_W-1:0] keep);
    logic [SLOT_W-1:0] pick;
    case (sel_policy)
      POL_FCFS: begin
        pick = pick_lowest(keep);
      end
      POL_RR: begin
        turns_left = (quantum_reg == '0) ? QUANT_W'(1) : quantum_reg;
        pick = pick_next_rr(keep);
      end
      default: begin
        pick = pick_shortest(keep);
      end
    endcase
    return pick;
  endfunction

  // one admit or tick applied to the model, returns the expected result
  function automatic outcome_t schedule_step(input logic act, input logic [SLOT_W-1:0] slot,
                                             input logic [REM_W-1:0] burst);
    outcome_t          res;
    logic [SLOT_W-1:0] prev;
    logic [SLOT_W-1:0] cur;
    logic [SLOT_W-1:0] cand;
    logic              fin;
    prev = run_slot;
    cur  = run_slot;
    fin  = 1'b0;
    if (act == ACT_ADMIT) begin
      burst_left[slot] = burst;
      if (sel_policy == POL_SRTF) begin
        cand = pick_shortest(cur);
        if (burst_left[cur] == '0 || burst_left[cand] < burst_left[cur]) cur = cand;
      end
    end else begin
      if (burst_left[cur] == '0) cur = pick_by_policy(cur);
      if (burst_left[cur] != '0) begin
        burst_left[cur] = burst_left[cur] - 1'b1;
        fin = (burst_left[cur] == '0);
        if (sel_policy == POL_RR) begin
          if (turns_left != '0) turns_left = turns_left - 1'b1;
          if (fin || turns_left == '0) cur = pick_by_policy(cur);
        end else if (fin) begin
          cur = pick_by_policy(cur);
        end
      end
    end
    run_slot      = cur;
    res.slot      = cur;
    res.remaining = burst_left[cur];
    res.idle      = ~any_live();
    res.finished  = fin;
    res.switched  = (cur != prev);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // idle patterns shared by both sides
  // --------------------------------------------------------------------------
  // flips now and then between random waits and a run of back-to-back items
  function automatic int draw_wait(inout logic quiet);
    if ($urandom_range(0, 47) == 0) quiet = ~quiet;
    return quiet ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic note_mismatch(input string what);
    if (mismatches < MAX_PRINTS) $display("%0t ns  mismatch: %s", $time, what);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------
  logic tx_quiet = 1'b0;

  // offer one item, hold it until the transaction, then predict its result;
  // valid stays high afterwards so back-to-back items need no extra edge
  task automatic feed(input logic act, input logic [SLOT_W-1:0] slot,
                      input logic [REM_W-1:0] burst, input logic typed, input outcome_t want);
    int       gap;
    outcome_t pred;
    gap = draw_wait(tx_quiet);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_slot   <= slot;
    in_burst  <= burst;
    do @(posedge clk); while (in_stall);
    pred = schedule_step(act, slot, burst);
    outcome_q.push_back(typed ? want : pred);
  endtask

  // one register write, cfg_valid left high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_POLICY) sel_policy = policy_e'(val[POL_W-1:0]);
    else if (idx == CFG_QUANTUM) quantum_reg = val;
  endtask

  // drain all pending results, then set policy and quantum
  task automatic retune(input policy_e pol, input logic [QUANT_W-1:0] quant);
    while (outcome_q.size() != 0) @(posedge clk);
    // upper data bits of the policy write are don't-care
    write_reg(CFG_POLICY, {(CFG_DATA_W-POL_W)'($urandom), pol});
    write_reg(CFG_QUANTUM, quant);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    policy_e            cur_pol;
    logic [QUANT_W-1:0] cur_quant;
    logic               act;
    logic [SLOT_W-1:0]  slot;
    logic [REM_W-1:0]   burst;
    int                 pick;

    // model at reset
    foreach (burst_left[i]) burst_left[i] = '0;
    run_slot    = '0;
    turns_left  = QUANT_RST;
    quantum_reg = QUANT_RST;
    sel_policy  = POL_FCFS;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // write to the unused index, taken during the clearing pass, no effect
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    cur_pol   = POL_FCFS;
    cur_quant = QUANT_RST;

    // directed table walk, registers changed only between groups
    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].pol != cur_pol || DIRECTED[r].quant != cur_quant) begin
        in_valid <= 1'b0;
        cur_pol   = DIRECTED[r].pol;
        cur_quant = DIRECTED[r].quant;
        retune(cur_pol, cur_quant);
      end
      feed(DIRECTED[r].act, DIRECTED[r].slot, DIRECTED[r].burst,
           DIRECTED[r].typed, DIRECTED[r].want);
    end

    // random traffic: small bursts on a few slots so jobs finish, tie and
    // preempt often; a few full-range and empty bursts mixed in
    for (int p = 0; p < PHASES; p++) begin
      in_valid <= 1'b0;
      retune(PHASE_POL[p], PHASE_QUANT[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        act = ($urandom_range(0, 99) < 35) ? ACT_ADMIT : ACT_TICK;
        if (act == ACT_TICK) begin
          // slot and burst ignored on a tick
          slot  = SLOT_W'($urandom);
          burst = REM_W'($urandom);
        end else begin
          slot = ($urandom_range(0, 99) < 60) ? SLOT_W'($urandom_range(0, 7))
                                               : SLOT_W'($urandom_range(0, NSLOTS - 1));
          pick = $urandom_range(0, 99);
          if (pick < 10)      burst = '0;
          else if (pick < 80) burst = REM_W'($urandom_range(1, 6));
          else if (pick < 95) burst = REM_W'($urandom_range(7, 40));
          else if (pick < 98) burst = REM_W'($urandom);
          else                burst = '1;
        end
        feed(act, slot, burst, 1'b0, NO_CHECK);
      end
    end
    in_valid <= 1'b0;

    // wait out the last results, then watch for strays
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (END_SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // receiver side: random stalls per result, one long hold-off so the block
  // backs up and stalls its input while items keep coming
  // --------------------------------------------------------------------------
  initial begin
    logic rx_quiet;
    logic held;
    int   n;
    rx_quiet = 1'b0;
    held     = 1'b0;
    forever begin
      n = draw_wait(rx_quiet);
      if (!held && results_seen >= HOLD_AT) begin
        n    = HOLD_CYCLES;
        held = 1'b1;
      end
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // result checker, one transaction per accepted result
  always @(posedge clk) begin
    outcome_t seen;
    outcome_t want;
    if (rst_n && out_valid && !out_stall) begin
      seen = '{out_slot, out_remaining, out_idle, out_finished, out_switched};
      if (outcome_q.size() == 0) begin
        note_mismatch($sformatf("result %0d with nothing expected", results_seen));
      end else begin
        want = outcome_q.pop_front();
        if (seen.slot !== want.slot)
          note_mismatch($sformatf("result %0d running_slot %0d, expected %0d",
                                  results_seen, seen.slot, want.slot));
        if (seen.remaining !== want.remaining)
          note_mismatch($sformatf("result %0d running_remaining %0d, expected %0d",
                                  results_seen, seen.remaining, want.remaining));
        if (seen.idle !== want.idle)
          note_mismatch($sformatf("result %0d idle %b, expected %b",
                                  results_seen, seen.idle, want.idle));
        if (seen.finished !== want.finished)
          note_mismatch($sformatf("result %0d finished %b, expected %b",
                                  results_seen, seen.finished, want.finished));
        if (seen.switched !== want.switched)
          note_mismatch($sformatf("result %0d switched %b, expected %b",
                                  results_seen, seen.switched, want.switched));
      end
      results_seen++;
    end
  end

  // watchdog, several times the slowest legal run
  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
